/* src/fdsg_pkg.sv */
// Shared types and constants of the filled disc span generator.
package fdsg_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned RAD_W      = 5;
  localparam int unsigned COLOUR_W   = 24;
  localparam int unsigned SPAN_XY_W  = 13;
  localparam int unsigned SPAN_W_W   = 6;
  localparam int unsigned MAX_RADIUS = 31;
  // error term of the half-width walker, wide enough for -(2*32^2)
  localparam int unsigned ERR_W      = 13;

  // disc request as held between front and back
  typedef struct packed {
    logic [COLOUR_W-1:0]       colour;
    logic [RAD_W-1:0]          radius;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_x;
    logic                      single;   // zero radius: one one-pixel span
  } disc_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_e;

endpackage

/* src/fdsg_if.sv */
// Handshake channels for disc requests and spans.
interface fdsg_req_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [fdsg_pkg::COORD_W-1:0]         center_x;
  logic signed [fdsg_pkg::COORD_W-1:0]         center_y;
  logic        [fdsg_pkg::RAD_W-1:0]           radius;
  logic        [fdsg_pkg::COLOUR_W-1:0]        colour;

  modport source (output valid, center_x, center_y, radius, colour, input ready);
  modport sink   (input valid, center_x, center_y, radius, colour, output ready);
endinterface

interface fdsg_span_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [fdsg_pkg::SPAN_XY_W-1:0]       span_x;
  logic signed [fdsg_pkg::SPAN_XY_W-1:0]       span_y;
  logic        [fdsg_pkg::SPAN_W_W-1:0]        span_width;
  logic        [fdsg_pkg::COLOUR_W-1:0]        span_colour;
  logic                                        last_span;

  modport source (output valid, span_x, span_y, span_width, span_colour, last_span,
                  input ready);
  modport sink   (input valid, span_x, span_y, span_width, span_colour, last_span,
                  output ready);
endinterface

/* src/fdsg_front.sv */
// Front stage: accept a disc request, saturate the radius, flag zero radius.
module fdsg_front #(
  parameter int unsigned MAX_RADIUS = fdsg_pkg::MAX_RADIUS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  fdsg_req_if.sink        req_i,
  output logic            disc_valid_o,
  input  logic            disc_ready_i,
  output fdsg_pkg::disc_t disc_o
);

  logic            valid_q, valid_d;
  fdsg_pkg::disc_t disc_q;
  fdsg_pkg::disc_t disc_d;
  logic            accept;
  logic [fdsg_pkg::RAD_W-1:0] rad_sat;

  // take a new beat when the holding register is empty or drains this cycle
  assign req_i.ready = !valid_q || disc_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  // clamp the radius and classify the request
  always_comb begin
    if (req_i.radius > fdsg_pkg::RAD_W'(MAX_RADIUS)) begin
      rad_sat = fdsg_pkg::RAD_W'(MAX_RADIUS);
    end else begin
      rad_sat = req_i.radius;
    end
    disc_d.colour   = req_i.colour;
    disc_d.radius   = rad_sat;
    disc_d.center_y = req_i.center_y;
    disc_d.center_x = req_i.center_x;
    disc_d.single   = (rad_sat == '0);
  end

  // hold until the queue takes it
  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (disc_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      disc_q <= disc_d;
    end
  end

  assign disc_valid_o = valid_q;
  assign disc_o       = disc_q;

endmodule

/* src/fdsg_queue.sv */
// Two-entry queue of classified discs between front and back.
module fdsg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  fdsg_pkg::disc_t push_disc_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output fdsg_pkg::disc_t pop_disc_o
);

  fdsg_pkg::disc_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_disc_o   = slot_q[rd_ptr_q];

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_disc_i;
    end
  end

endmodule

/* src/fdsg_back.sv */
// Back stage: walk the rows of one disc and emit one span beat per row.
module fdsg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            disc_valid_i,
  output logic            disc_ready_o,
  input  fdsg_pkg::disc_t disc_i,
  fdsg_span_if.source     span_o
);

  localparam int unsigned EW = fdsg_pkg::ERR_W;
  localparam int unsigned RW = fdsg_pkg::RAD_W;
  localparam int unsigned XW = fdsg_pkg::SPAN_XY_W;

  fdsg_pkg::back_state_e state_q, state_d;

  fdsg_pkg::disc_t   cur_q;
  logic [RW-1:0]     a_q, a_d;       // |row offset from centre|
  logic [RW-1:0]     h_q, h_d;       // current half-width
  logic              bottom_q, bottom_d;
  // err = r^2 - y^2 - (h+1)^2: sign tells whether h+1 still fits
  logic signed [EW-1:0] e_q, e_d;

  logic              out_valid_q, out_valid_d;
  logic signed [XW-1:0] out_x_q, out_y_q;
  logic [fdsg_pkg::SPAN_W_W-1:0] out_w_q;
  logic [fdsg_pkg::COLOUR_W-1:0] out_c_q;
  logic              out_last_q;

  logic signed [EW-1:0] h2_s, a2_s, e_fit;
  logic              load, emit, fire, last_row, out_free;
  logic signed [XW-1:0] cx_s, cy_s, h_s, a_s, row_y;

  assign h2_s  = $signed({{(EW-RW-1){1'b0}}, h_q, 1'b0});
  assign a2_s  = $signed({{(EW-RW-1){1'b0}}, a_q, 1'b0});
  // r^2 - y^2 - h^2: current half-width fits when non-negative
  assign e_fit = e_q + h2_s + EW'(1);

  assign cx_s  = $signed({cur_q.center_x[fdsg_pkg::COORD_W-1], cur_q.center_x});
  assign cy_s  = $signed({cur_q.center_y[fdsg_pkg::COORD_W-1], cur_q.center_y});
  assign h_s   = $signed({{(XW-RW){1'b0}}, h_q});
  assign a_s   = $signed({{(XW-RW){1'b0}}, a_q});
  assign row_y = bottom_q ? (cy_s + a_s) : (cy_s - a_s);

  assign last_row = cur_q.single || (bottom_q && (a_q == cur_q.radius));
  assign out_free = !out_valid_q || span_o.ready;

  // decide between a half-width step and a span beat
  always_comb begin
    if (state_q != fdsg_pkg::ST_RUN) begin
      emit = 1'b0;
    end else if (!bottom_q) begin
      emit = e_q[EW-1];
    end else begin
      emit = (h_q == '0) || !e_fit[EW-1];
    end
  end
  assign fire = emit && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdsg_pkg::ST_IDLE: begin
        if (disc_valid_i) begin
          state_d = fdsg_pkg::ST_RUN;
        end
      end
      fdsg_pkg::ST_RUN: begin
        if (fire && last_row) begin
          state_d = fdsg_pkg::ST_IDLE;
        end
      end
      default: state_d = fdsg_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (state_q)
      fdsg_pkg::ST_IDLE: load = disc_valid_i;
      fdsg_pkg::ST_RUN:  load = 1'b0;
      default:           load = 1'b0;
    endcase
  end
  assign disc_ready_o = load;

  // row walker: grow on the upper half, shrink on the lower half, step rows
  always_comb begin
    a_d      = a_q;
    h_d      = h_q;
    bottom_d = bottom_q;
    e_d      = e_q;
    if (load) begin
      a_d      = disc_i.radius;
      h_d      = '0;
      bottom_d = 1'b0;
      e_d      = -EW'(1);
    end else if (state_q == fdsg_pkg::ST_RUN) begin
      if (!emit) begin
        if (!bottom_q) begin
          h_d = h_q + RW'(1);
          e_d = e_q - h2_s - EW'(3);
        end else begin
          h_d = h_q - RW'(1);
          e_d = e_fit;
        end
      end else if (fire && !last_row) begin
        if (!bottom_q) begin
          if (a_q == '0) begin
            bottom_d = 1'b1;
            a_d      = RW'(1);
            e_d      = e_q - EW'(1);
          end else begin
            a_d = a_q - RW'(1);
            e_d = e_q + a2_s - EW'(1);
          end
        end else begin
          a_d = a_q + RW'(1);
          e_d = e_q - a2_s - EW'(1);
        end
      end
    end
  end

  // output register: drop on take, refill on a span beat
  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (span_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdsg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    h_q      <= h_d;
    bottom_q <= bottom_d;
    e_q      <= e_d;
    if (load) begin
      cur_q <= disc_i;
    end
    if (fire) begin
      out_x_q    <= cx_s - h_s;
      out_y_q    <= row_y;
      out_w_q    <= {h_q, 1'b1};
      out_c_q    <= cur_q.colour;
      out_last_q <= last_row;
    end
  end

  assign span_o.valid       = out_valid_q;
  assign span_o.span_x      = out_x_q;
  assign span_o.span_y      = out_y_q;
  assign span_o.span_width  = out_w_q;
  assign span_o.span_colour = out_c_q;
  assign span_o.last_span   = out_last_q;

endmodule

/* src/filled_disc_span_generator_top.sv */
// Top level of the filled disc span generator.
//
//  channel  dir  beat                                        accepted when
//  req_i    in   center_x, center_y, radius, colour          valid && ready
//  span_o   out  span_x, span_y, span_width, span_colour,    valid && ready
//                last_span
//
// A disc of radius r gives 2r+1 span beats, top row first. The back stage
// walks the half-width one step per cycle and takes 2r half-width steps per
// disc besides its span beats and the load of the disc.
// The front register and a two-entry queue take new requests while the back
// is busy. A stalled span_o holds the back stage; reset clears all control.
module filled_disc_span_generator_top #(
  parameter int unsigned MAX_RADIUS = fdsg_pkg::MAX_RADIUS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdsg_req_if.sink   req_i,
  fdsg_span_if.source span_o
);

  logic            f_valid, f_ready;
  fdsg_pkg::disc_t f_disc;
  logic            b_valid, b_ready;
  fdsg_pkg::disc_t b_disc;

  fdsg_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .disc_valid_o (f_valid),
    .disc_ready_i (f_ready),
    .disc_o       (f_disc)
  );

  fdsg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_disc_i  (f_disc),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_disc_o   (b_disc)
  );

  fdsg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .disc_valid_i (b_valid),
    .disc_ready_o (b_ready),
    .disc_i       (b_disc),
    .span_o       (span_o)
  );

  // spans are always odd and never wider than the largest disc
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_o.valid |-> (span_o.span_width[0] &&
                      (span_o.span_width <= fdsg_pkg::SPAN_W_W'(2 * MAX_RADIUS + 1))))
    else $error("span width out of range");

  // a full queue is never seen as empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !f_ready |-> b_valid)
    else $error("queue full and empty at once");

  // the back takes a disc only when the queue offers one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_ready |-> b_valid)
    else $error("back stage pops an empty queue");

  // queued radius never exceeds the clamp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid |-> (b_disc.radius <= fdsg_pkg::RAD_W'(MAX_RADIUS)))
    else $error("radius not clamped");

endmodule
